[rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 byte converter.
// Used by the decoder and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int UNIT_W    = 16;
  localparam int PARTIAL_W = 10;
  localparam int PEND_W    = 2;

  // Lead byte ranges of the sequences that are decoded.
  localparam logic [7:0] ASCII_HI = 8'h7F;
  localparam logic [7:0] LEAD2_LO = 8'hC0;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;

  // Continuation bytes still awaited.
  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

  // A finished code unit as the decoder hands it to the output stage.
  typedef struct packed {
    logic              valid;
    logic [UNIT_W-1:0] code;
  } unit_t;

endpackage

[rtl/utf8_to_utf16_byte_converter.sv]
// Top level of the UTF-8 to UTF-16 byte converter.
// Instantiates u8u16_decode and uses u8u16_pkg for the unit type.
`timescale 1ns / 1ps

// The input channel takes one UTF-8 byte per beat, with frame_end marking the
// last byte of a buffer; an open sequence is then dropped. The output channel
// gives each finished UTF-16 code unit as two beats, out_last high on the
// second. cfg_write loads big_endian_out from cfg_data: 0 sends the low byte
// first, 1 the high byte first. Write it only while the block is idle.
// A byte is decoded at the edge that accepts it; the first beat of its unit
// is offered in the next cycle and the second beat once the first is taken.
// An input byte is taken whenever the unit register is empty or its second
// beat leaves in the same cycle, so bytes that open or continue a sequence
// go through at one per cycle while the unit register is empty; a byte after
// one that finishes a unit waits for the single unit register's two beats.
// While the receiver stalls, the current beat holds and in_stall is raised
// once the unit register cannot be freed. Reset empties the unit register,
// closes any open sequence and selects low byte first.

module utf8_to_utf16_byte_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  u8u16_pkg::unit_t             dec_unit;
  logic                         in_take;
  logic                         out_take;
  logic                         big_endian_out;
  logic                         unit_valid;
  logic                         unit_phase;
  logic [u8u16_pkg::UNIT_W-1:0] unit_code;
  logic                         send_high;

  assign out_take = unit_valid && !out_stall;
  assign in_stall = unit_valid && !(unit_phase && !out_stall);
  assign in_take  = in_valid && !in_stall;

  u8u16_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .frame_end (frame_end),
    .take      (in_take),
    .unit      (dec_unit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian_out <= 1'b0;
      unit_valid     <= 1'b0;
      unit_phase     <= 1'b0;
    end else begin
      if (cfg_write) begin
        big_endian_out <= cfg_data;
      end
      if (in_take && dec_unit.valid) begin
        unit_valid <= 1'b1;
        unit_phase <= 1'b0;
        unit_code  <= dec_unit.code;
      end else if (out_take) begin
        if (unit_phase) begin
          unit_valid <= 1'b0;
          unit_phase <= 1'b0;
        end else begin
          unit_phase <= 1'b1;
        end
      end
    end
  end

  // The high byte goes first in big endian order and second otherwise.
  assign send_high = big_endian_out ^ unit_phase;
  assign out_valid = unit_valid;
  assign out_last  = unit_phase;
  assign out_byte  = send_high ? unit_code[15:8] : unit_code[7:0];

  // The first beat of a unit is always followed by its second beat.
  a_second_beat: assert property (@(posedge clk) disable iff (rst)
    (out_take && !out_last) |=> (out_valid && out_last))
    else $error("first beat not followed by second beat");

  // Once the second beat leaves and no new unit arrives, the output is empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_last && !(in_take && dec_unit.valid)) |=> !out_valid)
    else $error("output still valid after the last beat left");

  // A finished unit is never accepted over a beat that still waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_take && dec_unit.valid) |-> (!unit_valid || (out_take && out_last)))
    else $error("unit register overwritten before it was sent");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

[rtl/u8u16_decode.sv]
// UTF-8 sequence decoder: holds the open sequence and finishes code units.
// Depends on u8u16_pkg for the unit type and the lead byte ranges.
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                frame_end,
  input  logic                take,
  output u8u16_pkg::unit_t    unit
);

  logic [u8u16_pkg::PEND_W-1:0]    bytes_pending, bytes_pending_next;
  logic [u8u16_pkg::PARTIAL_W-1:0] partial_bits, partial_bits_next;
  logic [u8u16_pkg::UNIT_W-1:0]    acc;

  assign acc = {partial_bits, in_byte[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_bits_next  = partial_bits;
    unit.valid         = 1'b0;
    unit.code          = acc;
    if (bytes_pending == u8u16_pkg::PEND_ONE) begin
      // Last continuation: the unit is complete.
      bytes_pending_next = u8u16_pkg::PEND_NONE;
      partial_bits_next  = '0;
      unit.valid         = 1'b1;
    end else if (bytes_pending == u8u16_pkg::PEND_TWO) begin
      bytes_pending_next = u8u16_pkg::PEND_ONE;
      partial_bits_next  = acc[u8u16_pkg::PARTIAL_W-1:0];
    end else begin
      bytes_pending_next = u8u16_pkg::PEND_NONE;
      if (in_byte inside {[8'h00:u8u16_pkg::ASCII_HI]}) begin
        unit.valid = 1'b1;
        unit.code  = {8'h00, in_byte};
      end else if (in_byte inside {[u8u16_pkg::LEAD2_LO:u8u16_pkg::LEAD2_HI]}) begin
        bytes_pending_next = u8u16_pkg::PEND_ONE;
        partial_bits_next  = {5'd0, in_byte[4:0]};
      end else if (in_byte inside {[u8u16_pkg::LEAD3_LO:u8u16_pkg::LEAD3_HI]}) begin
        bytes_pending_next = u8u16_pkg::PEND_TWO;
        partial_bits_next  = {6'd0, in_byte[3:0]};
      end
      // Stray continuation bytes and long lead bytes fall through unused.
    end
    // The end of a frame drops a sequence that is still open.
    if (frame_end && (bytes_pending_next != u8u16_pkg::PEND_NONE)) begin
      bytes_pending_next = u8u16_pkg::PEND_NONE;
      partial_bits_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= u8u16_pkg::PEND_NONE;
      partial_bits  <= '0;
    end else if (take) begin
      bytes_pending <= bytes_pending_next;
      partial_bits  <= partial_bits_next;
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for utf8_to_utf16_byte_converter.
// Needs rtl/u8u16_pkg.sv and the block's RTL; the byte-order predictor and
// the queue of expected UTF-16 beats live in the unit_tracker class below.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } beat_t;

  // Follows the UTF-8 decode state and queues the output beats it predicts.
  class unit_tracker;
    bit                                high_first;
    logic [u8u16_pkg::PEND_W-1:0]    pending;
    logic [u8u16_pkg::PARTIAL_W-1:0] partial;
    beat_t                             beats_due[$];
    int                                mismatches;

    function new();
      high_first = 1'b0;
      pending    = u8u16_pkg::PEND_NONE;
      partial    = '0;
      mismatches = 0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void queue_unit(logic [u8u16_pkg::UNIT_W-1:0] unit);
      beat_t first_beat;
      beat_t second_beat;
      first_beat.data     = high_first ? unit[15:8] : unit[7:0];
      first_beat.is_last  = 1'b0;
      second_beat.data    = high_first ? unit[7:0] : unit[15:8];
      second_beat.is_last = 1'b1;
      beats_due = {beats_due, first_beat, second_beat};
    endfunction

    function void take_utf8_byte(logic [7:0] b, logic fe);
      logic [u8u16_pkg::UNIT_W-1:0] acc;
      if (pending == u8u16_pkg::PEND_ONE || pending == u8u16_pkg::PEND_TWO) begin
        // Any byte counts as a continuation here; only its low six bits matter.
        acc     = {partial, b[5:0]};
        pending = pending - 1'b1;
        if (pending == u8u16_pkg::PEND_NONE) begin
          partial = '0;
          queue_unit(acc);
        end else begin
          partial = acc[u8u16_pkg::PARTIAL_W-1:0];
        end
      end else begin
        pending = u8u16_pkg::PEND_NONE;
        if (b <= u8u16_pkg::ASCII_HI) begin
          queue_unit({8'h00, b});
        end else if (b >= u8u16_pkg::LEAD2_LO && b <= u8u16_pkg::LEAD2_HI) begin
          pending = u8u16_pkg::PEND_ONE;
          partial = {5'd0, b[4:0]};
        end else if (b >= u8u16_pkg::LEAD3_LO && b <= u8u16_pkg::LEAD3_HI) begin
          pending = u8u16_pkg::PEND_TWO;
          partial = {6'd0, b[3:0]};
        end
      end
      if (fe && pending != u8u16_pkg::PEND_NONE) begin
        pending = u8u16_pkg::PEND_NONE;
        partial = '0;
      end
    endfunction

    function void check_utf16_beat(logic [7:0] data, logic is_last);
      beat_t want;
      if (beats_due.size() == 0) begin
        flag($sformatf("unexpected beat byte=%02h last=%b", data, is_last));
        return;
      end
      want = beats_due.pop_front();
      if (want.data !== data || want.is_last !== is_last)
        flag($sformatf("expected byte=%02h last=%b, got byte=%02h last=%b",
                       want.data, want.is_last, data, is_last));
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data  = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_cycles = 0;

  unit_tracker tracker = new();

  // Directed bytes as {frame_end, byte}.
  logic [8:0] opening_bytes [0:24] = '{
    {1'b0, 8'h00}, {1'b0, 8'h7F},                 // ASCII extremes
    {1'b0, 8'h80}, {1'b0, 8'hBF},                 // stray continuations
    {1'b0, 8'hF0}, {1'b0, 8'hFF},                 // four-byte and longer leads
    {1'b0, 8'hC0}, {1'b0, 8'h80},                 // overlong zero
    {1'b0, 8'hDF}, {1'b0, 8'hBF},                 // largest two-byte value
    {1'b0, 8'hE0}, {1'b0, 8'h80}, {1'b0, 8'h80},  // smallest three-byte form
    {1'b0, 8'hEF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},  // continuations not checked
    {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b0, 8'h80},  // surrogate value passes
    {1'b0, 8'hE2}, {1'b1, 8'h82},                 // frame ends mid-sequence
    {1'b1, 8'hC3},                                // frame ends on a lead byte
    {1'b0, 8'hC2}, {1'b1, 8'h41},                 // frame end on completing byte
    {1'b1, 8'h41}
  };

  utf8_to_utf16_byte_converter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #2 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Both channels are sampled here, before the edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_utf16_beat(out_byte, out_last);
      if (in_valid && !in_stall) tracker.take_utf8_byte(in_byte, frame_end);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fe);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_order(input bit high_first);
    in_valid <= 1'b0;
    while (tracker.beats_due.size() != 0) @(posedge clk);
    // Bytes that only open or continue a sequence may still be settling.
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= high_first;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.high_first = high_first;
  endtask

  function automatic logic [7:0] continuation_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Mostly whole characters with random content; the rest is noise and
  // sequences cut short by a frame end.
  task automatic send_random_item(inout int sent);
    int         pick;
    int         len;
    int         cut;
    int         k;
    logic [7:0] b;
    logic       fe;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      len = $urandom_range(1, 3);
      cut = len;
      fe  = ($urandom_range(0, 9) == 0);
      if (pick >= 65 && len > 1) begin
        cut = $urandom_range(1, len - 1);
        fe  = 1'b1;
      end
      for (k = 0; k < cut; k++) begin
        if (k > 0) b = continuation_byte();
        else if (len == 1) b = {1'b0, 7'($urandom)};
        else if (len == 2) b = {3'b110, 5'($urandom)};
        else b = {4'b1110, 4'($urandom)};
        send_byte(b, (k == cut - 1) ? fe : 1'b0);
        sent++;
      end
    end else begin
      b = 8'($urandom);
      send_byte(b, ($urandom_range(0, 7) == 0));
      if (!((b >= 8'h80 && b <= 8'hBF) || b >= 8'hF0)) sent++;
    end
  endtask

  task automatic run_random(input int count, input int hold_at);
    int sent;
    sent = 0;
    while (sent < count) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_cycles = 400;
        hold_at     = -1;
      end
      send_random_item(sent);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle = 37;
    recv_idle = 59;
    set_order(1'b0);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    set_order(1'b1);
    run_random(350, -1);

    send_idle = 59;
    recv_idle = 37;
    set_order(1'b0);
    run_random(350, -1);

    // No idling; the receiver's long hold-off backs the block up into its input.
    send_idle = 0;
    recv_idle = 0;
    set_order(1'b1);
    run_random(350, 100);

    in_valid <= 1'b0;
    while (tracker.beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.beats_due.size() == 0) begin
      $display("** utf8_to_utf16_byte_converter: PASSED **");
    end else begin
      $display("** utf8_to_utf16_byte_converter: FAILED **");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("** utf8_to_utf16_byte_converter: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/utf8_to_utf16_byte_converter.sv
dv/tb_top.sv
